>>> rtl/tick_task_scheduler_top_macros.svh
// Assertion helpers used by the checker file tts_checker.sv.
// Both sample on clk and stay quiet while rst_n is low.
`ifndef TICK_TASK_SCHEDULER_TOP_MACROS_SVH
`define TICK_TASK_SCHEDULER_TOP_MACROS_SVH

// Same-cycle implication.
`define TTS_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication.
`define TTS_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

>>> rtl/tts_pkg.sv
package tts_pkg;

    localparam int SLOTS_DEFAULT = 8;
    localparam int MAX_RESULTS   = 8;

    localparam int ACTION_W = 2;
    localparam int TAG_W     = 16;
    localparam int COUNT_W   = 16;
    localparam int PENDING_W = 8;
    localparam int TARGET_W  = 3;
    localparam int RUN_CNT_W = $clog2(MAX_RESULTS + 1);

    localparam logic [PENDING_W-1:0] PENDING_MAX = '1;

    localparam logic [ACTION_W-1:0] ACT_ADD      = 2'd0;
    localparam logic [ACTION_W-1:0] ACT_DELETE   = 2'd1;
    localparam logic [ACTION_W-1:0] ACT_TICK     = 2'd2;
    localparam logic [ACTION_W-1:0] ACT_DISPATCH = 2'd3;

    localparam logic KIND_ADD = 1'b0;
    localparam logic KIND_RUN = 1'b1;

    typedef struct packed {
        logic [TAG_W-1:0]     tag;
        logic [COUNT_W-1:0]   countdown;
        logic [COUNT_W-1:0]   period;
        logic [PENDING_W-1:0] pending;
    } slot_entry_t;

    typedef struct packed {
        logic has_pending;
        logic one_shot;
    } slot_status_t;

endpackage

>>> rtl/tts_slot_alu.sv
// Shared slot update unit: one decrement/increment and zero compare path.
module tts_slot_alu
(
    input  logic                 op_tick,
    input  tts_pkg::slot_entry_t cur,
    output tts_pkg::slot_entry_t nxt,
    output tts_pkg::slot_status_t status
);

    always_comb
    begin
        nxt                = cur;
        status.has_pending = (cur.pending != '0);
        status.one_shot    = (cur.period == '0);
        if (op_tick)
        begin
            if (cur.countdown == '0)
            begin
                if (cur.pending != tts_pkg::PENDING_MAX)
                begin
                    nxt.pending = cur.pending + tts_pkg::PENDING_W'(1);
                end
                if (cur.period != '0)
                begin
                    nxt.countdown = cur.period;
                end
            end
            else
            begin
                nxt.countdown = cur.countdown - tts_pkg::COUNT_W'(1);
            end
        end
        else
        begin
            // dispatch: take one run off the count
            nxt.pending = cur.pending - tts_pkg::PENDING_W'(1);
        end
    end

endmodule

>>> rtl/tts_slot_mem.sv
// Slot table storage: one write port, one read port, registered read data.
module tts_slot_mem
#(
    parameter int SLOTS = tts_pkg::SLOTS_DEFAULT,
    localparam int PTR_W = (SLOTS > 1) ? $clog2(SLOTS) : 1
)
(
    input  logic                 clk,
    input  logic                 wr_en,
    input  logic [PTR_W-1:0]     wr_addr,
    input  tts_pkg::slot_entry_t wr_data,
    input  logic                 rd_en,
    input  logic [PTR_W-1:0]     rd_addr,
    output tts_pkg::slot_entry_t rd_data
);

    tts_pkg::slot_entry_t mem [SLOTS];
    tts_pkg::slot_entry_t rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

>>> rtl/tick_task_scheduler_top.sv
// Time-triggered cooperative task scheduler. A table of SLOTS task slots keeps a tag,
// a countdown, a repeat period and a pending-run count per slot. An item on the
// request channel is one command: add (answers with the lowest free slot, or SLOTS
// when the table is full), delete (no answer), tick (no answer; every occupied slot
// counts down, and a slot at zero gains a pending run, saturating at 255, and reloads
// its period if nonzero) or dispatch (one run request per ready slot in slot order, at
// most eight, last_of_run on the final one; a single run_valid=0 answer when nothing
// is ready; a one-shot slot is freed when run). Commands are handled one at a time and
// req_stall stays high while one is in progress. A delete is done as it is accepted. Add
// walks the occupancy bits one slot per cycle and stops at the first free slot or at the
// last slot. Tick walks all slots and dispatch walks them until the last slot or the eighth
// run: a free slot takes a scan step only, an occupied one a scan step that reads the slot
// memory and then an update step through the one shared update unit, and a closing step
// follows the walk. An add or a dispatch also waits whenever the response register is
// full and stalled. The response register lets a new command be accepted while the
// previous answer is still waiting on rsp_stall.
module tick_task_scheduler_top
#(
    parameter int SLOTS = tts_pkg::SLOTS_DEFAULT,
    localparam int SLOT_W = $clog2(SLOTS + 1)
)
(
    input  logic                          clk,
    input  logic                          rst_n,

    input  logic                          req_valid,
    output logic                          req_stall,
    input  logic [tts_pkg::ACTION_W-1:0]  action,
    input  logic [tts_pkg::TAG_W-1:0]     task_tag,
    input  logic [tts_pkg::COUNT_W-1:0]   start_delay,
    input  logic [tts_pkg::COUNT_W-1:0]   repeat_period,
    input  logic [tts_pkg::TARGET_W-1:0]  target_slot,

    output logic                          rsp_valid,
    input  logic                          rsp_stall,
    output logic                          result_kind,
    output logic [SLOT_W-1:0]             slot_index,
    output logic [tts_pkg::TAG_W-1:0]     run_tag,
    output logic                          run_valid,
    output logic                          last_of_run
);

    localparam int PTR_W = (SLOTS > 1) ? $clog2(SLOTS) : 1;
    localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(SLOTS - 1);
    localparam logic [SLOT_W-1:0] FULL_INDEX = SLOT_W'(SLOTS);

    // sequencer states
    localparam logic [1:0] ST_IDLE = 2'd0;  // wait for a command
    localparam logic [1:0] ST_SCAN = 2'd1;  // look at the slot under the pointer
    localparam logic [1:0] ST_EXEC = 2'd2;  // update an occupied slot from memory
    localparam logic [1:0] ST_FIN  = 2'd3;  // hand over the final answer, if any

    logic [1:0]                        state_reg, state_next;
    logic [SLOTS-1:0]                  used_reg, used_next;
    logic [PTR_W-1:0]                  ptr_reg, ptr_next;
    logic [tts_pkg::RUN_CNT_W-1:0]     run_cnt_reg, run_cnt_next;
    logic                              hold_valid_reg, hold_valid_next;
    logic                              rsp_valid_reg, rsp_valid_next;

    // latched command
    logic [tts_pkg::ACTION_W-1:0]      action_reg, action_next;
    logic [tts_pkg::TAG_W-1:0]         tag_reg, tag_next;
    logic [tts_pkg::COUNT_W-1:0]       delay_reg, delay_next;
    logic [tts_pkg::COUNT_W-1:0]       period_reg, period_next;

    // run request held back until we know whether it is the last one
    logic [SLOT_W-1:0]                 hold_slot_reg, hold_slot_next;
    logic [tts_pkg::TAG_W-1:0]         hold_tag_reg, hold_tag_next;

    // response register
    logic                              kind_reg, kind_next;
    logic [SLOT_W-1:0]                 slot_reg, slot_next;
    logic [tts_pkg::TAG_W-1:0]         rtag_reg, rtag_next;
    logic                              rvalid_reg, rvalid_next;
    logic                              last_reg, last_next;

    logic                              accept;
    logic                              out_free;
    logic                              mem_wr_en;
    logic                              mem_rd_en;
    tts_pkg::slot_entry_t              mem_wr_data;
    tts_pkg::slot_entry_t              mem_rd_data;
    tts_pkg::slot_entry_t              alu_nxt;
    tts_pkg::slot_status_t             alu_status;

    assign req_stall   = (state_reg != ST_IDLE);
    assign accept      = req_valid && !req_stall;
    assign out_free    = !rsp_valid_reg || !rsp_stall;

    assign rsp_valid   = rsp_valid_reg;
    assign result_kind = kind_reg;
    assign slot_index  = slot_reg;
    assign run_tag     = rtag_reg;
    assign run_valid   = rvalid_reg;
    assign last_of_run = last_reg;

    tts_slot_mem #(
        .SLOTS   (SLOTS)
    ) u_mem (
        .clk     (clk),
        .wr_en   (mem_wr_en),
        .wr_addr (ptr_reg),
        .wr_data (mem_wr_data),
        .rd_en   (mem_rd_en),
        .rd_addr (ptr_reg),
        .rd_data (mem_rd_data)
    );

    tts_slot_alu u_alu (
        .op_tick (action_reg == tts_pkg::ACT_TICK),
        .cur     (mem_rd_data),
        .nxt     (alu_nxt),
        .status  (alu_status)
    );

    always_comb
    begin
        state_next      = state_reg;
        used_next       = used_reg;
        ptr_next        = ptr_reg;
        run_cnt_next    = run_cnt_reg;
        hold_valid_next = hold_valid_reg;
        hold_slot_next  = hold_slot_reg;
        hold_tag_next   = hold_tag_reg;
        action_next     = action_reg;
        tag_next        = tag_reg;
        delay_next      = delay_reg;
        period_next     = period_reg;
        kind_next       = kind_reg;
        slot_next       = slot_reg;
        rtag_next       = rtag_reg;
        rvalid_next     = rvalid_reg;
        last_next       = last_reg;
        mem_wr_en       = 1'b0;
        mem_rd_en       = 1'b0;
        mem_wr_data     = alu_nxt;

        // drop the answer once it is taken
        rsp_valid_next  = rsp_valid_reg && rsp_stall;

        case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    action_next     = action;
                    tag_next        = task_tag;
                    delay_next      = start_delay;
                    period_next     = repeat_period;
                    ptr_next        = '0;
                    run_cnt_next    = '0;
                    hold_valid_next = 1'b0;
                    if (action == tts_pkg::ACT_DELETE)
                    begin
                        // a target beyond the table matches no slot
                        for (int i = 0; i < SLOTS; i++)
                        begin
                            if (32'(target_slot) == i)
                            begin
                                used_next[i] = 1'b0;
                            end
                        end
                    end
                    else
                    begin
                        state_next = ST_SCAN;
                    end
                end
            end

            ST_SCAN:
            begin
                if (action_reg == tts_pkg::ACT_ADD)
                begin
                    if (!used_reg[ptr_reg])
                    begin
                        mem_wr_en           = 1'b1;
                        mem_wr_data.tag       = tag_reg;
                        mem_wr_data.countdown = delay_reg;
                        mem_wr_data.period    = period_reg;
                        mem_wr_data.pending   = '0;
                        used_next[ptr_reg]  = 1'b1;
                        hold_slot_next      = SLOT_W'(ptr_reg);
                        state_next          = ST_FIN;
                    end
                    else if (ptr_reg == LAST_PTR)
                    begin
                        hold_slot_next = FULL_INDEX;
                        state_next     = ST_FIN;
                    end
                    else
                    begin
                        ptr_next = ptr_reg + PTR_W'(1);
                    end
                end
                else if (used_reg[ptr_reg])
                begin
                    mem_rd_en  = 1'b1;
                    state_next = ST_EXEC;
                end
                else if (ptr_reg == LAST_PTR)
                begin
                    state_next = ST_FIN;
                end
                else
                begin
                    ptr_next = ptr_reg + PTR_W'(1);
                end
            end

            ST_EXEC:
            begin
                if (action_reg == tts_pkg::ACT_TICK)
                begin
                    mem_wr_en = 1'b1;
                    if (ptr_reg == LAST_PTR)
                    begin
                        state_next = ST_FIN;
                    end
                    else
                    begin
                        ptr_next   = ptr_reg + PTR_W'(1);
                        state_next = ST_SCAN;
                    end
                end
                else if (!alu_status.has_pending)
                begin
                    if (ptr_reg == LAST_PTR)
                    begin
                        state_next = ST_FIN;
                    end
                    else
                    begin
                        ptr_next   = ptr_reg + PTR_W'(1);
                        state_next = ST_SCAN;
                    end
                end
                else if (!hold_valid_reg || out_free)
                begin
                    // push the earlier run out, hold this one
                    if (hold_valid_reg)
                    begin
                        rsp_valid_next = 1'b1;
                        kind_next      = tts_pkg::KIND_RUN;
                        slot_next      = hold_slot_reg;
                        rtag_next      = hold_tag_reg;
                        rvalid_next    = 1'b1;
                        last_next      = 1'b0;
                    end
                    hold_valid_next = 1'b1;
                    hold_slot_next  = SLOT_W'(ptr_reg);
                    hold_tag_next   = mem_rd_data.tag;
                    run_cnt_next    = run_cnt_reg + tts_pkg::RUN_CNT_W'(1);
                    mem_wr_en       = 1'b1;
                    if (alu_status.one_shot)
                    begin
                        used_next[ptr_reg] = 1'b0;
                    end
                    if ((ptr_reg == LAST_PTR) ||
                        (run_cnt_reg == tts_pkg::RUN_CNT_W'(tts_pkg::MAX_RESULTS - 1)))
                    begin
                        state_next = ST_FIN;
                    end
                    else
                    begin
                        ptr_next   = ptr_reg + PTR_W'(1);
                        state_next = ST_SCAN;
                    end
                end
            end

            ST_FIN:
            begin
                if (action_reg == tts_pkg::ACT_TICK)
                begin
                    state_next = ST_IDLE;
                end
                else if (out_free)
                begin
                    rsp_valid_next = 1'b1;
                    last_next      = 1'b1;
                    state_next     = ST_IDLE;
                    if (action_reg == tts_pkg::ACT_ADD)
                    begin
                        kind_next   = tts_pkg::KIND_ADD;
                        slot_next   = hold_slot_reg;
                        rtag_next   = '0;
                        rvalid_next = 1'b0;
                    end
                    else if (hold_valid_reg)
                    begin
                        kind_next   = tts_pkg::KIND_RUN;
                        slot_next   = hold_slot_reg;
                        rtag_next   = hold_tag_reg;
                        rvalid_next = 1'b1;
                    end
                    else
                    begin
                        kind_next   = tts_pkg::KIND_RUN;
                        slot_next   = '0;
                        rtag_next   = '0;
                        rvalid_next = 1'b0;
                    end
                end
            end

            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_IDLE;
            used_reg       <= '0;
            ptr_reg        <= '0;
            run_cnt_reg    <= '0;
            hold_valid_reg <= 1'b0;
            rsp_valid_reg  <= 1'b0;
            action_reg     <= tts_pkg::ACT_ADD;
        end
        else
        begin
            state_reg      <= state_next;
            used_reg       <= used_next;
            ptr_reg        <= ptr_next;
            run_cnt_reg    <= run_cnt_next;
            hold_valid_reg <= hold_valid_next;
            rsp_valid_reg  <= rsp_valid_next;
            action_reg     <= action_next;
        end
    end

    always_ff @(posedge clk)
    begin
        tag_reg       <= tag_next;
        delay_reg     <= delay_next;
        period_reg    <= period_next;
        hold_slot_reg <= hold_slot_next;
        hold_tag_reg  <= hold_tag_next;
        kind_reg      <= kind_next;
        slot_reg      <= slot_next;
        rtag_reg      <= rtag_next;
        rvalid_reg    <= rvalid_next;
        last_reg      <= last_next;
    end

endmodule

>>> rtl/tts_checker.sv
`include "tick_task_scheduler_top_macros.svh"

module tts_checker
#(
    parameter int SLOTS = tts_pkg::SLOTS_DEFAULT,
    localparam int SLOT_W = $clog2(SLOTS + 1)
)
(
    input logic                          clk,
    input logic                          rst_n,
    input logic                          req_valid,
    input logic                          req_stall,
    input logic [tts_pkg::ACTION_W-1:0]  action,
    input logic                          rsp_valid,
    input logic                          rsp_stall,
    input logic                          result_kind,
    input logic [SLOT_W-1:0]             slot_index,
    input logic [tts_pkg::TAG_W-1:0]     run_tag,
    input logic                          run_valid,
    input logic                          last_of_run
);

    // hold a stalled answer
    `TTS_ASSERT_NEXT(a_rsp_hold, rsp_valid && rsp_stall, rsp_valid && $stable(slot_index) && $stable(run_tag) && $stable(last_of_run), "stalled answer changed")

    // a command other than delete keeps the block busy the next cycle
    `TTS_ASSERT_NEXT(a_busy_after_cmd, req_valid && !req_stall && (action != tts_pkg::ACT_DELETE), req_stall, "block not busy after command")

    // add answers never name a task to run
    `TTS_ASSERT_NOW(a_add_no_run, rsp_valid && (result_kind == tts_pkg::KIND_ADD), !run_valid && (run_tag == '0) && last_of_run, "malformed add answer")

    // an empty dispatch answer is a lone final item at slot zero
    `TTS_ASSERT_NOW(a_empty_dispatch, rsp_valid && (result_kind == tts_pkg::KIND_RUN) && !run_valid, last_of_run && (slot_index == '0) && (run_tag == '0), "malformed empty dispatch answer")

endmodule

bind tick_task_scheduler_top tts_checker #(.SLOTS(SLOTS)) u_tts_checker (.*);
